@@ rtl/rbf_pkg.sv @@
`default_nettype none

package rbf_pkg;

   localparam int KERNEL_SIZE   = 10;
   localparam int MAX_WIDTH     = 2048;
   localparam int CSR_W         = 12;
   localparam int WIDTH_RESET   = 640;
   localparam int CH_N          = 3;
   localparam int PIX_W         = 8;
   localparam int PIX_MAX       = 255;
   localparam int FRONT_Q_DEPTH = 4;
   localparam int OUT_Q_DEPTH   = 8;

   // channel 0 is red, in the lowest bits
   typedef logic [CH_N-1:0][PIX_W-1:0] pixel_type;

   typedef struct packed {
      logic emit;
      logic row_end;
   } tag_type;

   typedef struct packed {
      logic      row_end;
      pixel_type mean;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/rbf_ram.sv @@
`default_nettype none

module rbf_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ rtl/rbf_fifo.sv @@
`default_nettype none

module rbf_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic [WIDTH-1:0]           push_data,
   output logic                            full,
   input  wire logic                       pop,
   output logic      [WIDTH-1:0]           pop_data,
   output logic                            empty,
   output logic      [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

`default_nettype wire

@@ rtl/rbf_front.sv @@
`default_nettype none

module rbf_front #(
   parameter int KERNEL_SIZE = rbf_pkg::KERNEL_SIZE,
   parameter int MAX_WIDTH   = rbf_pkg::MAX_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [rbf_pkg::CSR_W-1:0]     csr_wdata,
   input  wire logic                          accept,
   input  wire logic                          sof,
   output logic      [$clog2(MAX_WIDTH)-1:0]  col,
   output rbf_pkg::tag_type                   tag
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(KERNEL_SIZE+1);
   localparam int EW = (CW + 1 > rbf_pkg::CSR_W) ? CW + 1 : rbf_pkg::CSR_W;

   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [EW-1:0] width_ff;
   logic [CW-1:0] col_cur;
   logic [RW-1:0] row_cur;
   logic          last;

   function automatic logic [EW-1:0] clamp_width(input logic [rbf_pkg::CSR_W-1:0] v);
      logic [EW-1:0] w;
      w = EW'(v);
      if (w < EW'(KERNEL_SIZE)) w = EW'(KERNEL_SIZE);
      if (w > EW'(MAX_WIDTH)) w = EW'(MAX_WIDTH);
      return w;
   endfunction

   always_comb begin
      col_cur     = sof ? '0 : col_ff;
      row_cur     = sof ? '0 : row_ff;
      last        = (EW'(col_cur) + EW'(1)) >= width_ff;
      tag.emit    = (row_cur >= RW'(KERNEL_SIZE - 1)) &&
                    (EW'(col_cur) >= EW'(KERNEL_SIZE - 1));
      tag.row_end = last;
   end

   assign col = col_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         width_ff <= clamp_width(rbf_pkg::CSR_W'(rbf_pkg::WIDTH_RESET));
      end else begin
         if (csr_we) begin
            width_ff <= clamp_width(csr_wdata);
         end
         if (accept) begin
            if (last) begin
               col_ff <= '0;
               // row count saturates at the kernel size
               if (row_cur < RW'(KERNEL_SIZE)) begin
                  row_ff <= row_cur + RW'(1);
               end else begin
                  row_ff <= row_cur;
               end
            end else begin
               col_ff <= col_cur + CW'(1);
               row_ff <= row_cur;
            end
         end
      end
   end

   a_row_saturates: assert property (@(posedge clock) disable iff (reset)
      row_ff <= RW'(KERNEL_SIZE))
      else $error("row count above kernel size");

   a_width_clamped: assert property (@(posedge clock) disable iff (reset)
      (width_ff <= EW'(MAX_WIDTH)) && width_ff != '0)
      else $error("effective width out of range");

endmodule

`default_nettype wire

@@ rtl/rbf_back.sv @@
`default_nettype none

module rbf_back #(
   parameter int KERNEL_SIZE = rbf_pkg::KERNEL_SIZE,
   parameter int MAX_WIDTH   = rbf_pkg::MAX_WIDTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_valid,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]       q_col,
   input  wire rbf_pkg::tag_type                   q_tag,
   input  wire rbf_pkg::pixel_type                 q_pixel,
   output logic                                    q_pop,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output rbf_pkg::pixel_type                      rsp_tdata,
   output logic                                    rsp_tlast
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int K     = KERNEL_SIZE;
   localparam int LINES = K - 1;
   localparam int CH_N  = rbf_pkg::CH_N;
   localparam int PIX_W = rbf_pkg::PIX_W;
   localparam int AREA  = K * K;
   localparam int CS_W  = $clog2(K * rbf_pkg::PIX_MAX + 1);
   localparam int SUM_W = $clog2(AREA * rbf_pkg::PIX_MAX + 1);
   localparam int LG    = $clog2(AREA);
   localparam int SH    = SUM_W + LG;
   localparam int MUL_W = SUM_W + 2;
   localparam int PW    = SUM_W + MUL_W;
   localparam longint unsigned MUL_L =
      ((longint'(1) << SH) + longint'(AREA) - 1) / longint'(AREA);
   localparam logic [MUL_W-1:0] MUL = MUL_W'(MUL_L);
   localparam int LV    = $clog2(K);
   localparam int N2    = 1 << LV;
   localparam int OQ_D  = rbf_pkg::OUT_Q_DEPTH;
   localparam int CNT_W = $clog2(OQ_D + 1);

   // stage 1: line store read data back, column sum
   logic               v1_ff;
   logic [CW-1:0]      col1_ff;
   rbf_pkg::tag_type   tag1_ff;
   rbf_pkg::pixel_type pix1_ff;
   logic               fwd_ff;
   rbf_pkg::pixel_type hold_ff [LINES];
   rbf_pkg::pixel_type ram_rd  [LINES];
   rbf_pkg::pixel_type rd_eff  [LINES];
   rbf_pkg::pixel_type wr_data [LINES];
   rbf_pkg::pixel_type vals    [N2];
   logic [CS_W-1:0]    tree    [CH_N][LV+1][N2];

   // stage 2: column sum registered
   logic               v2_ff;
   rbf_pkg::tag_type   tag2_ff;
   logic [CS_W-1:0]    cs2_ff [CH_N];

   // stage 3: window of column sums and running window sum
   logic               v3_ff;
   rbf_pkg::tag_type   tag3_ff;
   logic [CS_W-1:0]    cs_sh_ff [K][CH_N];
   logic [SUM_W-1:0]   ws_ff [CH_N];

   // stage 4: reciprocal product
   logic               v4_ff;
   rbf_pkg::tag_type   tag4_ff;
   logic [PW-1:0]      prod_ff [CH_N];

   rbf_pkg::result_type out_item;
   rbf_pkg::result_type out_head;
   logic                out_push;
   logic                out_full;
   logic                out_empty;
   logic [CNT_W-1:0]    out_count;
   logic [CNT_W:0]      committed;

   // an item is taken from the queue only if the result queue has room for it
   always_comb begin
      committed = (CNT_W+1)'(out_count) + (CNT_W+1)'(v1_ff) + (CNT_W+1)'(v2_ff) +
                  (CNT_W+1)'(v3_ff) + (CNT_W+1)'(v4_ff);
      q_pop     = q_valid && (committed < (CNT_W+1)'(OQ_D));
   end

   for (genvar g = 0; g < LINES; g++) begin : g_line
      rbf_ram #(
         .WIDTH ($bits(rbf_pkg::pixel_type)),
         .DEPTH (MAX_WIDTH)
      ) u_line (
         .clock (clock),
         .we    (v1_ff),
         .waddr (col1_ff),
         .wdata (wr_data[g]),
         .raddr (q_col),
         .rdata (ram_rd[g])
      );
   end

   // back-to-back items at the same column: take what was just written
   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         rd_eff[k] = fwd_ff ? hold_ff[k] : ram_rd[k];
      end
      wr_data[0] = pix1_ff;
      for (int k = 1; k < LINES; k++) begin
         wr_data[k] = rd_eff[k-1];
      end
   end

   always_comb begin
      for (int i = 0; i < N2; i++) begin
         vals[i] = '0;
      end
      vals[0] = pix1_ff;
      for (int k = 0; k < LINES; k++) begin
         vals[k+1] = rd_eff[k];
      end
      for (int c = 0; c < CH_N; c++) begin
         for (int l = 0; l <= LV; l++) begin
            for (int i = 0; i < N2; i++) begin
               tree[c][l][i] = '0;
            end
         end
         for (int i = 0; i < N2; i++) begin
            tree[c][0][i] = CS_W'(vals[i][c]);
         end
         for (int l = 0; l < LV; l++) begin
            for (int i = 0; i < (N2 >> (l + 1)); i++) begin
               tree[c][l+1][i] = tree[c][l][2*i] + tree[c][l][2*i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      col1_ff <= q_col;
      tag1_ff <= q_tag;
      pix1_ff <= q_pixel;
      for (int k = 0; k < LINES; k++) begin
         hold_ff[k] <= wr_data[k];
      end
      tag2_ff <= tag1_ff;
      for (int c = 0; c < CH_N; c++) begin
         cs2_ff[c] <= tree[c][LV][0];
      end
      tag3_ff <= tag2_ff;
      tag4_ff <= tag3_ff;
      for (int c = 0; c < CH_N; c++) begin
         prod_ff[c] <= PW'(ws_ff[c]) * PW'(MUL);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         fwd_ff <= 1'b0;
         for (int k = 0; k < K; k++) begin
            for (int c = 0; c < CH_N; c++) begin
               cs_sh_ff[k][c] <= '0;
            end
         end
         for (int c = 0; c < CH_N; c++) begin
            ws_ff[c] <= '0;
         end
      end else begin
         v1_ff  <= q_pop;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         fwd_ff <= q_pop && v1_ff && (q_col == col1_ff);
         if (v2_ff) begin
            // running sum: add the new column, drop the oldest
            for (int c = 0; c < CH_N; c++) begin
               ws_ff[c] <= ws_ff[c] + SUM_W'(cs2_ff[c]) - SUM_W'(cs_sh_ff[K-1][c]);
               cs_sh_ff[0][c] <= cs2_ff[c];
            end
            for (int k = 1; k < K; k++) begin
               cs_sh_ff[k] <= cs_sh_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      out_item.row_end = tag4_ff.row_end;
      for (int c = 0; c < CH_N; c++) begin
         out_item.mean[c] = prod_ff[c][SH +: PIX_W];
      end
      out_push = v4_ff && tag4_ff.emit;
   end

   rbf_fifo #(
      .WIDTH ($bits(rbf_pkg::result_type)),
      .DEPTH (OQ_D)
   ) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_item),
      .full      (out_full),
      .pop       (rsp_tvalid && rsp_tready),
      .pop_data  (out_head),
      .empty     (out_empty),
      .count     (out_count)
   );

   assign rsp_tvalid = !out_empty;
   assign rsp_tdata  = out_head.mean;
   assign rsp_tlast  = out_head.row_end;

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result queue overrun");

   a_fwd_needs_item: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> v1_ff)
      else $error("line store bypass without an item");

   a_credit: assert property (@(posedge clock) disable iff (reset)
      committed <= (CNT_W+1)'(OQ_D))
      else $error("more items in flight than result queue room");

endmodule

`default_nettype wire

@@ rtl/rgb_box_filter_valid_core.sv @@
`default_nettype none

// K by K box-filter mean over an RGB pixel stream in raster order, valid region only.
// A result comes out for each pixel that closes a full window (K-1 rows and K-1 columns
// already seen in the frame); it carries floor(window sum / (K*K)) per channel, and tlast
// marks the last result of an output row. Unless the output stalls, the block takes one
// pixel per clock sustained: each of the K-1 line memories has one read and one write
// port and is read and written once per pixel, and the window sum is kept as a running
// add of the new column sum and subtract of the oldest. A pixel passes the front queue
// and the back-end stages into an eight-entry result queue; the two queues let either
// side stall without loss. tuser on the input restarts the row and column count. The
// row length is set through csr_wdata and is clamped to [KERNEL_SIZE, MAX_WIDTH]; change
// it only between frames. The line memories have no reset and need no clearing pass.
module rgb_box_filter_valid_core #(
   parameter int KERNEL_SIZE = rbf_pkg::KERNEL_SIZE,
   parameter int MAX_WIDTH   = rbf_pkg::MAX_WIDTH
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_tvalid,
   output logic                                         req_tready,
   // red [7:0], green [15:8], blue [23:16]
   input  wire logic [$bits(rbf_pkg::pixel_type)-1:0]   req_tdata,
   // start_of_frame
   input  wire logic                                    req_tuser,
   output logic                                         rsp_tvalid,
   input  wire logic                                    rsp_tready,
   // red_mean [7:0], green_mean [15:8], blue_mean [23:16]
   output logic      [$bits(rbf_pkg::pixel_type)-1:0]   rsp_tdata,
   output logic                                         rsp_tlast,
   input  wire logic                                    csr_we,
   input  wire logic [rbf_pkg::CSR_W-1:0]               csr_wdata
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int PXW = $bits(rbf_pkg::pixel_type);
   localparam int TGW = $bits(rbf_pkg::tag_type);
   localparam int QW  = CW + TGW + PXW;
   localparam int QCW = $clog2(rbf_pkg::FRONT_Q_DEPTH + 1);

   logic               accept;
   logic [CW-1:0]      front_col;
   rbf_pkg::tag_type   front_tag;
   logic [QW-1:0]      q_wdata;
   logic [QW-1:0]      q_rdata;
   logic               q_full;
   logic               q_empty;
   logic               q_pop;
   logic [QCW-1:0]     q_count;
   logic [CW-1:0]      q_col;
   rbf_pkg::tag_type   q_tag;
   rbf_pkg::pixel_type q_pixel;
   rbf_pkg::pixel_type rsp_pixel;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   rbf_front #(
      .KERNEL_SIZE (KERNEL_SIZE),
      .MAX_WIDTH   (MAX_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .sof       (req_tuser),
      .col       (front_col),
      .tag       (front_tag)
   );

   assign q_wdata = {front_col, front_tag, req_tdata};

   rbf_fifo #(
      .WIDTH (QW),
      .DEPTH (rbf_pkg::FRONT_Q_DEPTH)
   ) u_item_q (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty),
      .count     (q_count)
   );

   assign q_pixel = q_rdata[PXW-1:0];
   assign q_tag   = q_rdata[PXW +: TGW];
   assign q_col   = q_rdata[PXW+TGW +: CW];

   rbf_back #(
      .KERNEL_SIZE (KERNEL_SIZE),
      .MAX_WIDTH   (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (!q_empty),
      .q_col      (q_col),
      .q_tag      (q_tag),
      .q_pixel    (q_pixel),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_pixel),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = rsp_pixel;

   a_item_q_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCW'(rbf_pkg::FRONT_Q_DEPTH))
      else $error("item queue count past its depth");

endmodule

`default_nettype wire

@@ sim/tb_rgb_box_filter_valid_core.sv @@
`default_nettype none

module tb_rgb_box_filter_valid_core;

   localparam int KERNEL_SIZE   = rbf_pkg::KERNEL_SIZE;
   localparam int MAX_WIDTH     = rbf_pkg::MAX_WIDTH;
   localparam int CSR_W         = rbf_pkg::CSR_W;
   localparam int CH_N          = rbf_pkg::CH_N;
   localparam int PIX_W         = rbf_pkg::PIX_W;
   localparam int PIX_MAX       = rbf_pkg::PIX_MAX;
   localparam int LINES         = KERNEL_SIZE - 1;
   localparam int AREA          = KERNEL_SIZE * KERNEL_SIZE;
   localparam int SETTLE_CYCLES = 16;
   localparam int REPORT_LIMIT  = 10;

   typedef enum {
      FILL_UNIFORM, FILL_EXTREME, FILL_BRIGHT, FILL_DARK, FILL_WHITE, FILL_BLACK
   } fill_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   wire logic          req_tready;
   // red [7:0], green [15:8], blue [23:16]
   rbf_pkg::pixel_type req_tdata  = '0;
   // start_of_frame
   logic               req_tuser  = 1'b0;
   wire logic          rsp_tvalid;
   logic               rsp_tready = 1'b0;
   // red_mean [7:0], green_mean [15:8], blue_mean [23:16]
   wire logic [$bits(rbf_pkg::pixel_type)-1:0] rsp_tdata;
   wire logic          rsp_tlast;
   logic               csr_we     = 1'b0;
   logic [CSR_W-1:0]   csr_wdata  = '0;

   rgb_box_filter_valid_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [CSR_W-1:0]    width_reg = CSR_W'(rbf_pkg::WIDTH_RESET);
   int unsigned         col_pos   = 0;
   int unsigned         rows_done = 0;
   rbf_pkg::pixel_type  line_mem [LINES][MAX_WIDTH];
   logic [11:0]         col_sums [KERNEL_SIZE][CH_N];
   rbf_pkg::result_type pending_means [$];

   int unsigned errors          = 0;
   int unsigned results_checked = 0;
   int unsigned pixels_sent     = 0;
   bit          send_gaps       = 1'b1;
   bit          take_gaps       = 1'b1;
   int unsigned stall_left      = 0;

   function automatic int unsigned clamp_width(input logic [CSR_W-1:0] w);
      if (w < KERNEL_SIZE) return KERNEL_SIZE;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   function automatic rbf_pkg::pixel_type draw_pixel(input fill_type fill);
      rbf_pkg::pixel_type px;
      for (int c = 0; c < CH_N; c++) begin
         case (fill)
            FILL_UNIFORM: px[c] = PIX_W'($urandom_range(0, PIX_MAX));
            FILL_EXTREME: px[c] = $urandom_range(0, 1) ? PIX_W'(PIX_MAX) : '0;
            FILL_BRIGHT:  px[c] = PIX_W'($urandom_range(PIX_MAX - 15, PIX_MAX));
            FILL_DARK:    px[c] = PIX_W'($urandom_range(0, 15));
            FILL_WHITE:   px[c] = PIX_W'(PIX_MAX);
            default:      px[c] = '0;
         endcase
      end
      return px;
   endfunction

   task automatic note_failure(input string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic predict_window_mean(input rbf_pkg::pixel_type px, input logic sof);
      int unsigned         eff_w;
      int unsigned         col;
      logic [11:0]         cs [CH_N];
      logic [15:0]         win;
      rbf_pkg::pixel_type  above;
      rbf_pkg::result_type want;
      eff_w = clamp_width(width_reg);
      if (sof) begin
         col_pos   = 0;
         rows_done = 0;
      end
      col = col_pos;
      if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
      for (int c = 0; c < CH_N; c++) cs[c] = 12'(px[c]);
      // column sum over the stored rows, shifting each one down a line
      for (int k = LINES; k > 0; k--) begin
         above = line_mem[k-1][col];
         for (int c = 0; c < CH_N; c++) cs[c] += 12'(above[c]);
         if (k < LINES) line_mem[k][col] = above;
      end
      line_mem[0][col] = px;
      for (int k = KERNEL_SIZE - 1; k > 0; k--) col_sums[k] = col_sums[k-1];
      col_sums[0] = cs;
      if (rows_done >= LINES && col >= LINES) begin
         for (int c = 0; c < CH_N; c++) begin
            win = '0;
            for (int k = 0; k < KERNEL_SIZE; k++) win += 16'(col_sums[k][c]);
            want.mean[c] = PIX_W'(win / AREA);
         end
         want.row_end = (col + 1 >= eff_w);
         pending_means.push_back(want);
      end
      if (col + 1 >= eff_w) begin
         col_pos = 0;
         if (rows_done < KERNEL_SIZE) rows_done++;
      end else begin
         col_pos = col + 1;
      end
   endtask

   task automatic send_pixel(input rbf_pkg::pixel_type px, input logic sof);
      if (send_gaps && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      req_tuser  <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_window_mean(px, sof);
      pixels_sent++;
   endtask

   task automatic send_frame(input int unsigned rows, input int unsigned extra,
                             input fill_type fill, input bit with_sof);
      int unsigned total;
      total = rows * clamp_width(width_reg) + extra;
      for (int unsigned i = 0; i < total; i++)
         send_pixel(draw_pixel(fill), with_sof && i == 0);
   endtask

   // let the pipeline run dry before touching the width register
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(input logic [CSR_W-1:0] w);
      csr_we    <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we    <= 1'b0;
      width_reg = w;
   endtask

   // receiver side stalls
   always @(posedge clock) begin
      if (!take_gaps) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_means
      rbf_pkg::result_type want;
      bit                  bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_means.size() == 0) begin
            note_failure($sformatf("unexpected item: data %h last %b",
               rsp_tdata, rsp_tlast));
         end else begin
            want = pending_means.pop_front();
            bad  = (rsp_tlast != want.row_end);
            for (int c = 0; c < CH_N; c++)
               if (rsp_tdata[c*PIX_W +: PIX_W] != want.mean[c]) bad = 1'b1;
            if (bad)
               note_failure($sformatf(
                  "mismatch: expected rgb %0d/%0d/%0d last %b, got %0d/%0d/%0d last %b",
                  want.mean[0], want.mean[1], want.mean[2], want.row_end,
                  rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast));
         end
      end
   end

   // pixels before any frame mark at the width left by reset, then narrower rows
   task automatic test_no_sof_at_reset_width();
      send_frame(0, 40, FILL_UNIFORM, 1'b0);
      wait_idle();
      write_width(CSR_W'(KERNEL_SIZE));
      send_frame(KERNEL_SIZE + 1, 0, FILL_UNIFORM, 1'b0);
      wait_idle();
   endtask

   // below-minimum settings clamp to the kernel size: one result per row
   task automatic test_narrowest_width();
      write_width('0);
      send_frame(KERNEL_SIZE, 0, FILL_WHITE, 1'b1);
      wait_idle();
      write_width(CSR_W'(KERNEL_SIZE - 1));
      send_frame(KERNEL_SIZE + 1, 0, FILL_EXTREME, 1'b1);
      wait_idle();
   endtask

   // the row never grows, so nothing comes out
   task automatic test_sof_on_every_pixel();
      write_width(CSR_W'(12));
      for (int i = 0; i < 30; i++) send_pixel(draw_pixel(FILL_UNIFORM), 1'b1);
      wait_idle();
   endtask

   task automatic test_restart_mid_row();
      write_width(CSR_W'(12));
      send_frame(KERNEL_SIZE, 7, FILL_UNIFORM, 1'b1);
      send_frame(KERNEL_SIZE, 0, FILL_BRIGHT, 1'b1);
      wait_idle();
   endtask

   // narrower rows take effect in the middle of a row of the running frame
   task automatic test_shrink_mid_frame();
      write_width(CSR_W'(16));
      send_frame(KERNEL_SIZE, 14, FILL_UNIFORM, 1'b1);
      wait_idle();
      write_width(CSR_W'(12));
      send_frame(3, 0, FILL_UNIFORM, 1'b0);
      wait_idle();
   endtask

   // long rows: the start of a row at the widest setting and above it
   task automatic test_widest_rows();
      write_width(CSR_W'(MAX_WIDTH));
      send_frame(0, 60, FILL_UNIFORM, 1'b1);
      wait_idle();
      send_gaps = 1'b0;
      take_gaps = 1'b0;
      write_width('1);
      send_frame(0, 40, FILL_DARK, 1'b1);
      wait_idle();
      write_width(CSR_W'(KERNEL_SIZE + 6));
      send_gaps = 1'b1;
      take_gaps = 1'b1;
   endtask

   task automatic test_random_frames(input int unsigned target);
      int unsigned sent_here;
      int unsigned calm_from;
      int unsigned rows;
      int unsigned total;
      int unsigned pick;
      fill_type    fill;
      sent_here = 0;
      calm_from = target - target / 5;
      while (sent_here < target) begin
         if (sent_here >= calm_from) begin
            send_gaps = 1'b0;
            take_gaps = 1'b0;
         end else begin
            send_gaps = $urandom_range(0, 3) != 0;
            take_gaps = $urandom_range(0, 3) != 0;
         end
         if (sent_here < calm_from && $urandom_range(0, 1) == 0) begin
            wait_idle();
            pick = $urandom_range(0, 9);
            if (pick == 0)      write_width(CSR_W'($urandom_range(0, KERNEL_SIZE - 1)));
            else if (pick == 1) write_width(CSR_W'($urandom_range(25, 48)));
            else                write_width(CSR_W'($urandom_range(KERNEL_SIZE, 24)));
         end
         rows = $urandom_range(KERNEL_SIZE, KERNEL_SIZE + 4);
         if ($urandom_range(0, 5) == 0) rows = $urandom_range(1, KERNEL_SIZE - 1);
         fill  = fill_type'($urandom_range(FILL_UNIFORM, FILL_BLACK));
         total = rows * clamp_width(width_reg);
         // the last frame is cut short to keep the item count
         if (total > target - sent_here) total = target - sent_here;
         for (int unsigned i = 0; i < total; i++) begin
            // stray frame marks now and then restart the frame mid-row
            send_pixel(draw_pixel(fill), i == 0 || $urandom_range(0, 199) == 0);
            sent_here++;
            if (sent_here >= calm_from) begin
               send_gaps = 1'b0;
               take_gaps = 1'b0;
            end else if ($urandom_range(0, 399) == 0) begin
               wait_idle();
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      for (int k = 0; k < LINES; k++)
         for (int x = 0; x < MAX_WIDTH; x++) line_mem[k][x] = '0;
      for (int k = 0; k < KERNEL_SIZE; k++)
         for (int c = 0; c < CH_N; c++) col_sums[k][c] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_sof_at_reset_width();
      test_narrowest_width();
      test_sof_on_every_pixel();
      test_restart_mid_row();
      test_shrink_mid_frame();
      test_widest_rows();
      test_random_frames(350);
      $display("sent %0d pixels, checked %0d window means", pixels_sent, results_checked);
      $display("row widths from the clamped minimum to the clamped maximum, stray frame marks");
      if (errors == 0 && pending_means.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures, %0d means never arrived", errors, pending_means.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/rbf_pkg.sv
rtl/rbf_ram.sv
rtl/rbf_fifo.sv
rtl/rbf_front.sv
rtl/rbf_back.sv
rtl/rgb_box_filter_valid_core.sv
sim/tb_rgb_box_filter_valid_core.sv
